// File: rtl/hmb_pkg.sv
package hmb_pkg;

  // Defaults for the top-level parameters
  localparam int HIST_BINS_DEF = 512;
  localparam int ADC_BITS_DEF  = 14;

  // Field widths
  localparam int SAMPLE_W = 14;
  localparam int HIGH_W   = 15;
  localparam int COUNT_W  = 11;
  localparam int BASE_W   = 17;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 2;

  // Saturation limits
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] INDEX_MAX = '1;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] WINDOW_LOW_RST      = 14'd1300;
  localparam logic [HIGH_W-1:0]   WINDOW_HIGH_RST     = 15'd1800;
  localparam logic [COUNT_W-1:0]  COUNTED_SAMPLES_RST = 11'd1000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTED_SAMPLES = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
  } hmb_in_t;

  typedef struct packed {
    logic [BASE_W-1:0]  baseline_q3;
    logic [COUNT_W-1:0] peak_count;
  } hmb_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;    // latch the item and read its bin
    logic bump;    // write back the incremented bin
    logic sweep;   // clear the bin under the sweep counter and advance
    logic scan;    // feed the swept bin into the mode search
    logic report;  // present the result
  } hmb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic sweep_end;  // sweep counter is on the last bin
    logic last_item;  // latched item closes the waveform
  } hmb_stat_t;

endpackage

// File: rtl/hmb_ctrl.sv
module hmb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  hmb_pkg::hmb_stat_t stat,
  output hmb_pkg::hmb_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_BUMP   = 6'b000100,
    S_SCAN   = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_REPORT = 6'b100000
  } state_t;

  state_t state, state_next;

  // Sequence the fill, scan and clear of the histogram
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (stat.sweep_end) state_next = S_IDLE;
      S_IDLE:   if (start) state_next = S_BUMP;
      S_BUMP:   state_next = stat.last_item ? S_SCAN : S_IDLE;
      S_SCAN:   if (stat.sweep_end) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_REPORT;
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands
  always_comb begin
    busy       = (state != S_IDLE);
    cmd.take   = start && (state == S_IDLE);
    cmd.bump   = (state == S_BUMP);
    cmd.sweep  = (state == S_CLEAR) || (state == S_SCAN);
    cmd.scan   = (state == S_SCAN);
    cmd.report = (state == S_REPORT);
  end

endmodule

// File: rtl/hmb_dpath.sv
module hmb_dpath #(
  parameter int HIST_BINS = hmb_pkg::HIST_BINS_DEF,
  parameter int ADC_BITS  = hmb_pkg::ADC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hmb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hmb_pkg::CFG_W-1:0]        cfg_data,
  input  hmb_pkg::hmb_in_t                 item,
  input  hmb_pkg::hmb_cmd_t                cmd,
  output hmb_pkg::hmb_stat_t               stat,
  output hmb_pkg::hmb_out_t                result
);

  localparam int ADDR_W   = $clog2(HIST_BINS);
  localparam int SAMPLE_W = hmb_pkg::SAMPLE_W;
  localparam int HIGH_W   = hmb_pkg::HIGH_W;
  localparam int COUNT_W  = hmb_pkg::COUNT_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << ADC_BITS) - 1);
  localparam logic [HIGH_W-1:0] BINS_SPAN = HIGH_W'(HIST_BINS);
  localparam logic [ADDR_W-1:0] LAST_BIN  = ADDR_W'(HIST_BINS - 1);

  // Configuration registers
  logic [SAMPLE_W-1:0] window_low;
  logic [HIGH_W-1:0]   window_high;
  logic [COUNT_W-1:0]  counted_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_low      <= hmb_pkg::WINDOW_LOW_RST;
      window_high     <= hmb_pkg::WINDOW_HIGH_RST;
      counted_samples <= hmb_pkg::COUNTED_SAMPLES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hmb_pkg::REG_WINDOW_LOW:      window_low      <= cfg_data[SAMPLE_W-1:0];
        hmb_pkg::REG_WINDOW_HIGH:     window_high     <= cfg_data[HIGH_W-1:0];
        hmb_pkg::REG_COUNTED_SAMPLES: counted_samples <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Number of bins in use: window width clipped to the histogram size
  logic [HIGH_W-1:0] span_raw;
  logic [HIGH_W-1:0] span;

  always_comb begin
    span_raw = '0;
    if (window_high > {1'b0, window_low}) begin
      span_raw = window_high - {1'b0, window_low};
    end
    span = (span_raw > BINS_SPAN) ? BINS_SPAN : span_raw;
  end

  // Bin lookup for the incoming item
  logic [SAMPLE_W-1:0] s;
  logic [SAMPLE_W-1:0] diff;
  logic [ADDR_W-1:0]   bin;
  logic                count_en;
  logic [COUNT_W-1:0]  sample_index;

  always_comb begin
    s        = item.sample & SAMPLE_MASK;
    diff     = s - window_low;
    bin      = diff[ADDR_W-1:0];
    count_en = (sample_index < counted_samples) && (s >= window_low) &&
               ({1'b0, diff} < span);
  end

  // Latch the item and step the position within the waveform
  logic [ADDR_W-1:0] bin_q;
  logic              count_q;
  logic              last_q;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      bin_q   <= bin;
      count_q <= count_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      last_q       <= 1'b0;
    end else if (cmd.take) begin
      last_q <= item.last_sample;
      if (item.last_sample) begin
        sample_index <= '0;
      end else if (sample_index != hmb_pkg::INDEX_MAX) begin
        sample_index <= sample_index + 1'b1;
      end
    end
  end

  // Sweep counter for the scan and the clearing pass
  logic [ADDR_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.sweep) begin
      cnt <= (cnt == LAST_BIN) ? '0 : cnt + 1'b1;
    end
  end

  // Histogram memory: one read and one write port, registered read
  logic [COUNT_W-1:0] hist [HIST_BINS];
  logic [COUNT_W-1:0] rd_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [COUNT_W-1:0] bumped;

  always_comb begin
    rd_addr = cmd.take ? bin : cnt;
    bumped  = (rd_data == hmb_pkg::COUNT_MAX) ? rd_data : rd_data + 1'b1;
  end

  always_ff @(posedge clk) begin
    rd_data <= hist[rd_addr];
    if (cmd.bump && count_q) begin
      hist[bin_q] <= bumped;
    end else if (cmd.sweep) begin
      hist[cnt] <= '0;
    end
  end

  // Mode search: lowest bin with the strictly largest count
  logic              cmp_en_q;
  logic [ADDR_W-1:0] cmp_idx_q;
  logic [ADDR_W-1:0] best;
  logic [COUNT_W-1:0] best_count;
  logic              in_span;

  assign in_span = {{(HIGH_W-ADDR_W){1'b0}}, cmp_idx_q} < span;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en_q <= 1'b0;
    end else begin
      cmp_en_q <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_q <= cnt;
    if (cmd.bump) begin
      best       <= '0;
      best_count <= '0;
    end else if (cmp_en_q && in_span && (rd_data > best_count)) begin
      best       <= cmp_idx_q;
      best_count <= rd_data;
    end
  end

  // Result: (window_low + best) * 8 + 1, kept to the field width
  logic [HIGH_W-1:0] base_sum;

  always_comb begin
    base_sum           = {1'b0, window_low} + HIGH_W'(best);
    result.baseline_q3 = {base_sum[SAMPLE_W-1:0], 3'b001};
    result.peak_count  = best_count;
    stat.sweep_end     = (cnt == LAST_BIN);
    stat.last_item     = last_q;
  end

endmodule

// File: rtl/histogram_mode_baseline.sv
// A non-final item has its bin read when taken and is written back in S_BUMP; busy is high for 1.
// A final item is followed by a scan of all HIST_BINS bins; its result strobe comes
// after the write-back, the scan and a drain state. No new item is taken while busy.
// Reset: a clearing pass over all HIST_BINS bins zeroes the histogram; busy stays high.
// done is high for exactly one cycle per result; the receiver cannot stall.
module histogram_mode_baseline #(
  parameter int HIST_BINS = hmb_pkg::HIST_BINS_DEF,
  parameter int ADC_BITS  = hmb_pkg::ADC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  hmb_pkg::hmb_in_t              item,
  output logic                          done,
  output hmb_pkg::hmb_out_t             result,
  input  logic                          cfg_we,
  input  logic [hmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hmb_pkg::CFG_W-1:0]     cfg_data
);

  hmb_pkg::hmb_cmd_t  cmd;
  hmb_pkg::hmb_stat_t stat;

  hmb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  hmb_dpath #(
    .HIST_BINS (HIST_BINS),
    .ADC_BITS  (ADC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  assign done = cmd.report;

  // A result is only shown while the block is busy
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

  // Strobes never run back to back
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // A non-final item frees the block after one busy cycle
  a_item_turn: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !item.last_sample) |=> (busy && !done) ##1 !busy)
    else $error("non-final item did not complete in two cycles");

  // A final item never yields a strobe right after its write-back
  a_last_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last_sample) |=> busy ##1 (busy && !done))
    else $error("final item did not start the scan");

endmodule
